// ----- design/pkem_pkg.sv -----
// ----------------------------------------------------------------------------
// pkem_pkg
// Shared types, key codes and the fixed button map of the pad-to-key mapper.
// ----------------------------------------------------------------------------
package pkem_pkg;

  localparam int MAP_ENTRIES = 15;
  localparam int MAP_IDX_W   = 4;
  localparam int CODE_W      = 8;
  localparam int EVENT_W     = CODE_W + 1;

  // Input action codes.
  localparam logic ACTION_SCAN = 1'b0;
  localparam logic ACTION_POP  = 1'b1;

  // Menu modes.
  localparam logic [1:0] MODE_GAME   = 2'd0;
  localparam logic [1:0] MODE_SUB    = 2'd1;
  localparam logic [1:0] MODE_ROOT   = 2'd2;
  localparam logic [1:0] MODE_PROMPT = 2'd3;

  // Key codes.
  localparam logic [7:0] K_NONE   = 8'h00;
  localparam logic [7:0] K_TAB    = 8'h09;
  localparam logic [7:0] K_ENTER  = 8'h0D;
  localparam logic [7:0] K_ESC    = 8'h1B;
  localparam logic [7:0] K_COMMA  = 8'h2C;
  localparam logic [7:0] K_PERIOD = 8'h2E;
  localparam logic [7:0] K_BKSP   = 8'h7F;
  localparam logic [7:0] K_USE    = 8'hA2;
  localparam logic [7:0] K_FIRE   = 8'hA3;
  localparam logic [7:0] K_LEFT   = 8'hAC;
  localparam logic [7:0] K_UP     = 8'hAD;
  localparam logic [7:0] K_RIGHT  = 8'hAE;
  localparam logic [7:0] K_DOWN   = 8'hAF;
  localparam logic [7:0] K_RSHIFT = 8'hB6;
  localparam logic [7:0] K_RALT   = 8'hB8;

  // Pad button masks that the prompt mode singles out.
  localparam logic [15:0] PAD_CROSS   = 16'h4000;
  localparam logic [15:0] PAD_CIRCLE  = 16'h2000;
  localparam logic [15:0] PAD_OPTIONS = 16'h0008;

  localparam logic [15:0] MAP_MASK [MAP_ENTRIES] = '{
    16'h4000, 16'h2000, 16'h8000, 16'h1000, 16'h0010, 16'h0040, 16'h0080, 16'h0020,
    16'h0400, 16'h0800, 16'h0100, 16'h0200, 16'h0008, 16'h0002, 16'h0004
  };
  localparam logic [7:0] MAP_GAME [MAP_ENTRIES] = '{
    K_FIRE, K_USE, K_RALT, K_TAB, K_UP, K_DOWN, K_LEFT, K_RIGHT,
    K_COMMA, K_PERIOD, K_RSHIFT, K_RALT, K_ESC, K_ENTER, K_ENTER
  };
  localparam logic [7:0] MAP_SUB [MAP_ENTRIES] = '{
    K_ENTER, K_BKSP, K_NONE, K_NONE, K_UP, K_DOWN, K_LEFT, K_RIGHT,
    K_NONE, K_NONE, K_NONE, K_NONE, K_ESC, K_ENTER, K_ENTER
  };
  localparam logic [7:0] MAP_ROOT [MAP_ENTRIES] = '{
    K_ENTER, K_ESC, K_NONE, K_NONE, K_UP, K_DOWN, K_LEFT, K_RIGHT,
    K_NONE, K_NONE, K_NONE, K_NONE, K_ESC, K_ENTER, K_ENTER
  };

  // Key code that a newly pressed button latches in the given menu mode.
  function automatic logic [7:0] code_for(input logic [MAP_IDX_W-1:0] idx,
                                          input logic [1:0] mode,
                                          input logic [7:0] confirm,
                                          input logic [7:0] abort_code);
    logic [7:0] res;
    res = K_NONE;
    case (mode)
      MODE_PROMPT: begin
        if (MAP_MASK[idx] == PAD_CROSS) res = confirm;
        else if (MAP_MASK[idx] == PAD_CIRCLE) res = abort_code;
        else if (MAP_MASK[idx] == PAD_OPTIONS) res = K_ESC;
        else res = K_NONE;
      end
      MODE_ROOT: res = MAP_ROOT[idx];
      MODE_SUB:  res = MAP_SUB[idx];
      default:   res = MAP_GAME[idx];
    endcase
    return res;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_POP
  } state_e;

  typedef struct packed {
    logic scan_load;
    logic walk_start;
    logic walk_step;
    logic pop_read;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
  } status_t;

endpackage

// ----- design/pkem_ram.sv -----
// ----------------------------------------------------------------------------
// pkem_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pkem_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/pkem_ctrl.sv -----
// ----------------------------------------------------------------------------
// pkem_ctrl
// Sequencer for frame scans and event pops; owns both handshakes.
// ----------------------------------------------------------------------------
module pkem_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              action_i,
  input  logic              pad_absent_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output pkem_pkg::cmd_t    cmd_o,
  input  pkem_pkg::status_t status_i
);
  import pkem_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_acc;
  logic   out_free;

  assign in_acc   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACTION_POP) state_d = ST_POP;
          else if (!pad_absent_i) state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (status_i.walk_last) state_d = ST_IDLE;
      end
      ST_POP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_acc && action_i == ACTION_POP) begin
          cmd_o.pop_read = 1'b1;
        end
        if (in_acc && action_i == ACTION_SCAN && !pad_absent_i) begin
          cmd_o.scan_load  = 1'b1;
          cmd_o.walk_start = 1'b1;
        end
      end
      ST_WALK: cmd_o.walk_step = 1'b1;
      ST_POP:  cmd_o.out_load  = out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- design/pkem_dp.sv -----
// ----------------------------------------------------------------------------
// pkem_dp
// Button latches, code walk, event ring pointers and the output register.
// ----------------------------------------------------------------------------
module pkem_dp #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int CODE_COUNT   = 256,
  parameter int BUTTON_COUNT = 15
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pkem_pkg::cmd_t    cmd_i,
  output pkem_pkg::status_t status_o,
  input  logic [15:0]       buttons_i,
  input  logic [1:0]        menu_mode_i,
  input  logic [7:0]        confirm_key_i,
  input  logic [7:0]        abort_key_i,
  output logic              event_valid_o,
  output logic              event_pressed_o,
  output logic [7:0]        event_code_o
);
  import pkem_pkg::*;

  localparam int NB = (BUTTON_COUNT < MAP_ENTRIES) ? BUTTON_COUNT : MAP_ENTRIES;
  localparam int CW = $clog2(CODE_COUNT);
  localparam int PW = $clog2(QUEUE_DEPTH);

  logic              down_q    [NB];
  logic [CODE_W-1:0] latched_q [NB];
  logic [CODE_W-1:0] prev_q    [NB];
  logic [CW-1:0]     cnt_q;
  logic [PW-1:0]     head_q, head_d, tail_q, tail_d;
  logic [PW-1:0]     head_next, tail_next;
  logic              pop_empty_q;
  logic              ev_valid_q, ev_pressed_q;
  logic [CODE_W-1:0] ev_code_q;

  logic              now_hit, was_hit, full, push;
  logic [CODE_W-1:0] cur_code;
  logic [EVENT_W-1:0] rdata;

  assign head_next = (head_q == PW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign full      = (head_next == tail_q);
  assign cur_code  = CODE_W'(cnt_q);

  // Held state of the current code now and after the previous frame, both
  // rebuilt from the button latches.
  always_comb begin
    now_hit = 1'b0;
    was_hit = 1'b0;
    for (int i = 0; i < NB; i++) begin
      if (latched_q[i] != K_NONE && latched_q[i] == cur_code) now_hit = 1'b1;
      if (prev_q[i] != K_NONE && prev_q[i] == cur_code) was_hit = 1'b1;
    end
  end

  assign push = cmd_i.walk_step && (now_hit != was_hit) && !full;
  assign status_o.walk_last = (cnt_q == CW'(CODE_COUNT - 1));

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (push) head_d = head_next;
    if (cmd_i.pop_read && (head_q != tail_q)) tail_d = tail_next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NB; i++) begin
        down_q[i]    <= 1'b0;
        latched_q[i] <= K_NONE;
        prev_q[i]    <= K_NONE;
      end
      cnt_q  <= '0;
      head_q <= '0;
      tail_q <= '0;
    end else begin
      if (cmd_i.scan_load) begin
        for (int i = 0; i < NB; i++) begin
          prev_q[i] <= latched_q[i];
          if ((buttons_i & MAP_MASK[i]) != 16'h0000) begin
            if (!down_q[i]) begin
              down_q[i]    <= 1'b1;
              latched_q[i] <= code_for(MAP_IDX_W'(i), menu_mode_i, confirm_key_i,
                                       abort_key_i);
            end
          end else begin
            down_q[i]    <= 1'b0;
            latched_q[i] <= K_NONE;
          end
        end
      end
      if (cmd_i.walk_start) cnt_q <= '0;
      else if (cmd_i.walk_step) cnt_q <= cnt_q + 1'b1;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pop_read) pop_empty_q <= (head_q == tail_q);
    if (cmd_i.out_load) begin
      ev_valid_q   <= !pop_empty_q;
      ev_pressed_q <= pop_empty_q ? 1'b0 : rdata[CODE_W];
      ev_code_q    <= pop_empty_q ? K_NONE : rdata[CODE_W-1:0];
    end
  end

  pkem_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (head_q),
    .wdata_i ({now_hit, cur_code}),
    .re_i    (cmd_i.pop_read),
    .raddr_i (tail_q),
    .rdata_o (rdata)
  );

  assign event_valid_o   = ev_valid_q;
  assign event_pressed_o = ev_pressed_q;
  assign event_code_o    = ev_code_q;

endmodule

// ----- design/pad_to_key_event_mapper_unit.sv -----
// ----------------------------------------------------------------------------
// pad_to_key_event_mapper_unit
// Maps pad button frames to key press and release events in a ring queue.
// ----------------------------------------------------------------------------
// A frame transaction is taken and then walks all CODE_COUNT key codes, one a
// cycle, before the next transaction is taken; a frame with no pad data is
// taken without a walk. A pop reads the ring's registered port, and its result
// is then loaded into the output register once that register is free; no new
// transaction is taken before that. Reset clears the button latches, the
// ring pointers and the result valid flag; the ring memory is left as it is.
// ----------------------------------------------------------------------------
module pad_to_key_event_mapper_unit #(
  parameter int QUEUE_DEPTH  = 64,
  parameter int CODE_COUNT   = 256,
  parameter int BUTTON_COUNT = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] buttons_i,
  input  logic        pad_absent_i,
  input  logic [1:0]  menu_mode_i,
  input  logic [7:0]  confirm_key_i,
  input  logic [7:0]  abort_key_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        event_valid_o,
  output logic        event_pressed_o,
  output logic [7:0]  event_code_o
);
  import pkem_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The controller decides when a transaction is taken and sequences the
  // scan walk and the pop; it sees the payload only as far as the action and
  // the pad-absent flag need.
  pkem_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .pad_absent_i (pad_absent_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .cmd_o        (cmd),
    .status_i     (status)
  );

  // The datapath keeps the latched code of every button together with the
  // set from the previous frame, so the held state of any code before and
  // after the frame is rebuilt by comparison during the walk. Changed codes
  // are written to the ring in ascending order; a full ring drops them.
  pkem_dp #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .CODE_COUNT   (CODE_COUNT),
    .BUTTON_COUNT (BUTTON_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .buttons_i       (buttons_i),
    .menu_mode_i     (menu_mode_i),
    .confirm_key_i   (confirm_key_i),
    .abort_key_i     (abort_key_i),
    .event_valid_o   (event_valid_o),
    .event_pressed_o (event_pressed_o),
    .event_code_o    (event_code_o)
  );

endmodule

// ----- design/pkem_checker.sv -----
// ----------------------------------------------------------------------------
// pkem_checker
// Port-level checks on the pad-to-key mapper, bound to the top level.
// ----------------------------------------------------------------------------
module pkem_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        action_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        event_valid_o,
  input logic        event_pressed_o,
  input logic [7:0]  event_code_o
);

  // A result held back must keep its fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(event_valid_o) &&
      $stable(event_pressed_o) && $stable(event_code_o))
    else $error("stalled result changed");

  // A frame transaction never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !action_i && !out_valid_o |=> !out_valid_o)
    else $error("frame produced a result");

  // Code zero never reaches the queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_valid_o |-> event_code_o != 8'h00)
    else $error("event with code zero");

  // An empty-queue reply carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !event_valid_o |-> !event_pressed_o && event_code_o == 8'h00)
    else $error("empty reply with non-zero fields");

endmodule

bind pad_to_key_event_mapper_unit pkem_checker u_pkem_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .action_i        (action_i),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .event_valid_o   (event_valid_o),
  .event_pressed_o (event_pressed_o),
  .event_code_o    (event_code_o)
);
